FILE: rtl/core/aprf_pkg.sv
// ----------------------------------------------------------------------------
// aprf_pkg: shared types and helpers for the AArch64 PC-relative fixup
// Relocation kinds, encoding masks and the word rewrite function.
// ----------------------------------------------------------------------------
`default_nettype none

package aprf_pkg;

   localparam int CMD_W    = 3;
   localparam int WORD_W   = 32;
   localparam int ADDR_W   = 64;
   // Low address bits that still matter: page delta needs bits 32..12
   localparam int ADDR_KEEP_W = 33;
   localparam int DELTA_W  = 28;   // byte delta bits 27..0 feed the branch and ADR fields
   localparam int PAGE_W   = 21;   // page delta bits 20..0
   localparam int REQ_DATA_W = WORD_W + 2 * ADDR_W;
   localparam int REQ_USER_W = 8;

   typedef enum logic [CMD_W-1:0] {
      KIND_BRANCH   = 3'd0,
      KIND_ADRP_ADD = 3'd1,
      KIND_ADRP     = 3'd2,
      KIND_ADR      = 3'd3,
      KIND_NONE     = 3'd4
   } kind_type;

   localparam logic [31:0] B_MASK      = 32'h7C00_0000;
   localparam logic [31:0] B_OPC       = 32'h1400_0000;
   localparam logic [31:0] B_KEEP      = 32'hFC00_0000;
   localparam logic [31:0] TOP8_MASK   = 32'hFF00_0000;
   localparam logic [31:0] BCOND_OPC   = 32'h5400_0000;
   localparam logic [31:0] IMM19_KEEP  = 32'hFF00_001F;
   localparam logic [31:0] TOP7_MASK   = 32'h7F00_0000;
   localparam logic [31:0] CBZ_OPC     = 32'h3400_0000;
   localparam logic [31:0] CBNZ_OPC    = 32'h3500_0000;
   localparam logic [31:0] TBZ_OPC     = 32'h3600_0000;
   localparam logic [31:0] TBNZ_OPC    = 32'h3700_0000;
   localparam logic [31:0] IMM14_KEEP  = 32'hFFF8_001F;
   localparam logic [31:0] ADR_KEEP    = 32'h9F00_001F;

   // ADR/ADRP immediate: immlo in 30..29, immhi in 23..5
   function automatic logic [WORD_W-1:0] put_adr_imm(
      input logic [WORD_W-1:0] w,
      input logic [PAGE_W-1:0] d
   );
      return (w & ADR_KEEP) | {1'b0, d[1:0], 5'd0, d[20:2], 5'd0};
   endfunction

   function automatic logic [WORD_W-1:0] fix_branch(
      input logic [WORD_W-1:0]  w,
      input logic [DELTA_W-1:0] d
   );
      logic [WORD_W-1:0] top;
      top = w & TOP7_MASK;
      if ((w & B_MASK) == B_OPC)
         return (w & B_KEEP) | {6'd0, d[27:2]};
      else if ((w & TOP8_MASK) == BCOND_OPC)
         return (w & IMM19_KEEP) | {8'd0, d[20:2], 5'd0};
      else if (top == CBZ_OPC || top == CBNZ_OPC)
         return (w & IMM19_KEEP) | {8'd0, d[20:2], 5'd0};
      else if (top == TBZ_OPC || top == TBNZ_OPC)
         return (w & IMM14_KEEP) | {13'd0, d[15:2], 5'd0};
      else
         return w;
   endfunction

   function automatic logic [WORD_W-1:0] fix_word(
      input logic [CMD_W-1:0]   kind,
      input logic [WORD_W-1:0]  w,
      input logic [DELTA_W-1:0] byte_d,
      input logic [PAGE_W-1:0]  page_d
   );
      logic [WORD_W-1:0] res;
      unique case (kind) inside
         KIND_BRANCH:             res = fix_branch(w, byte_d);
         KIND_ADRP_ADD, KIND_ADRP: res = put_adr_imm(w, page_d);
         KIND_ADR:                res = put_adr_imm(w, byte_d[PAGE_W-1:0]);
         default:                 res = w;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aarch64_pc_relative_fixup.sv
// ----------------------------------------------------------------------------
// aarch64_pc_relative_fixup: PC-relative immediate re-encoder
// Rewrites the branch, ADR or ADRP immediate of one instruction word so
// that it reaches its resolved target from a new address.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one item per instruction word. tuser carries
//   the relocation kind (0 branch, 1 adrp+add, 2 adrp, 3 adr, 4 none;
//   other codes pass the word unchanged). tdata carries the word, the
//   resolved target address and the new instruction address.
//   Response channel (rsp_*): one item per request item, in order, with
//   the patched word. Out-of-range offsets are silently truncated.
//   rsp_tvalid rises once an accepted item has passed the input register,
//   then the result register.
//   Throughput: 1 item per cycle while rsp_tready is high; the work per item is
//   one 28-bit and one 21-bit subtract plus field muxing, done in a single
//   pass between the two registers.
//   Reset (synchronous, active high) empties both stages; no item is lost
//   or produced afterwards. When rsp_tready is low the result register
//   holds; the input register still accepts while it is empty, then
//   req_tready drops until the response side drains.
// ----------------------------------------------------------------------------
`default_nettype none

module aarch64_pc_relative_fixup
   import aprf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [31:0] insn_word, [95:32] target_addr, [159:96] new_pc
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] cmd, upper bits unused
   input  wire logic [REQ_USER_W-1:0] req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [31:0] patched_word
   output logic [WORD_W-1:0]          rsp_tdata
);

   // Stage 1: input register (only the address bits that affect a field;
   // high address bits and spare tuser bits cannot reach any field)
   logic                    s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]        kind_ff;
   logic [WORD_W-1:0]       word_ff;
   logic [ADDR_KEEP_W-1:0]  tgt_ff;
   logic [ADDR_KEEP_W-1:0]  pc_ff;

   // Stage 2: result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]       rsp_word_ff;

   logic                    req_take;
   logic                    s2_load;
   logic                    s2_free;
   logic [DELTA_W-1:0]      byte_delta;
   logic [PAGE_W-1:0]       page_diff;
   logic [WORD_W-1:0]       patched;

   // Result register can take a new word when empty or being drained.
   assign s2_free    = !rsp_valid_ff || rsp_tready;
   assign s2_load    = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s2_free;
   assign req_take   = req_tvalid && req_tready;

   // Modulo-2^64 deltas, kept only as wide as the widest field needs.
   assign byte_delta = tgt_ff[DELTA_W-1:0] - pc_ff[DELTA_W-1:0];
   assign page_diff  = tgt_ff[ADDR_KEEP_W-1:12] - pc_ff[ADDR_KEEP_W-1:12];
   assign patched    = fix_word(kind_ff, word_ff, byte_delta, page_diff);

   assign s1_valid_in  = req_take || (s1_valid_ff && !s2_free);
   assign rsp_valid_in = s2_load  || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_tuser[CMD_W-1:0];
         word_ff <= req_tdata[WORD_W-1:0];
         tgt_ff  <= req_tdata[WORD_W +: ADDR_KEEP_W];
         pc_ff   <= req_tdata[WORD_W + ADDR_W +: ADDR_KEEP_W];
      end
      if (s2_load) begin
         rsp_word_ff <= patched;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_take_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted item did not land in the input register");

   a_s1_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff && $stable(word_ff))
      else $error("stalled input register lost its item");

   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      s2_load |=> rsp_tvalid && rsp_tdata == $past(patched))
      else $error("result register did not capture the patched word");

   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff && !rsp_valid_ff |-> req_tready)
      else $error("empty pipeline refused an item");

   a_adr_opcode_kept : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (kind_ff == KIND_ADR || kind_ff == KIND_ADRP
                      || kind_ff == KIND_ADRP_ADD)
      |-> (patched & ADR_KEEP) == (word_ff & ADR_KEEP))
      else $error("ADR/ADRP rewrite touched opcode or register bits");

endmodule

`default_nettype wire
